// ===== sv/ost_pkg.sv =====
`timescale 1ns / 1ps
// Package for the ordered set table: sizes, operation and status codes,
// and the command/status structs between controller and datapath. No dependencies.
package ost_pkg;

    // Table size and derived widths
    localparam int CAPACITY = 16;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Payload widths
    localparam int FUNC_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef logic [FUNC_W-1:0]   t_func;
    typedef logic [STATUS_W-1:0] t_status;

    // Operation codes
    localparam t_func FN_MEMBER = 2'd0;
    localparam t_func FN_INSERT = 2'd1;
    localparam t_func FN_REMOVE = 2'd2;

    // Result status codes
    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_MISS = 2'd1;
    localparam t_status ST_FULL = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic capture;      // latch the item value
        logic start_scan;   // rewind the search walk
        logic scan_en;      // advance the search walk
        logic start_shift;  // set up compaction from the hit slot
        logic shift_en;     // advance the compaction walk
        logic append;       // write value at the tail, count up
        logic dec_fill;     // count down after compaction
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic hit;          // compare stage matched
        logic scan_miss;    // all held entries searched, no match
        logic shift_done;   // compaction finished
        logic full;         // table holds CAPACITY entries
    } t_dp_sts;

endpackage

// ===== sv/ost_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the ordered set table.
// Depends on ost_pkg.
interface ost_req_if;
    import ost_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [FUNC_W-1:0]          func;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, func, value, input ready);
    modport sink   (input valid, func, value, output ready);
endinterface

interface ost_rsp_if;
    import ost_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [COUNT_W-1:0]     element_count;

    modport source (output valid, status, element_count, input ready);
    modport sink   (input valid, status, element_count, output ready);
endinterface

// ===== sv/ost_dpath.sv =====
`timescale 1ns / 1ps
// Datapath of the ordered set table: entry memory, search/compaction walk,
// compare stage and fill count. Depends on ost_pkg.
module ost_dpath
    import ost_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    input  logic signed [VALUE_W-1:0]  i_value,
    output t_dp_sts                    o_sts,
    output logic [CNT_W-1:0]           o_fill
);

    logic [VALUE_W-1:0] r_mem [CAPACITY];

    logic [VALUE_W-1:0] r_value;
    logic [CNT_W-1:0]   r_fill;
    logic [CNT_W-1:0]   r_rd_ptr;
    logic [ADDR_W-1:0]  r_rd_idx;
    logic [ADDR_W-1:0]  r_wr_ptr;
    logic               r_rd_vld;
    logic [VALUE_W-1:0] r_rd_data;

    logic w_more;
    logic w_step;

    assign w_more = (r_rd_ptr < r_fill);
    assign w_step = i_cmd.scan_en | i_cmd.shift_en;

    // Item value
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_value <= i_value;
        end
    end

    // Walk pointers and read pipeline valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_rd_idx <= '0;
            r_wr_ptr <= '0;
            r_rd_vld <= 1'b0;
        end else if (i_cmd.start_scan) begin
            r_rd_ptr <= '0;
            r_rd_vld <= 1'b0;
        end else if (i_cmd.start_shift) begin
            r_rd_ptr <= CNT_W'(r_rd_idx) + CNT_W'(1);
            r_wr_ptr <= r_rd_idx;
            r_rd_vld <= 1'b0;
        end else if (w_step) begin
            r_rd_vld <= w_more;
            if (w_more) begin
                r_rd_idx <= r_rd_ptr[ADDR_W-1:0];
                r_rd_ptr <= r_rd_ptr + CNT_W'(1);
            end
            if (i_cmd.shift_en && r_rd_vld) begin
                r_wr_ptr <= r_wr_ptr + ADDR_W'(1);
            end
        end
    end

    // Entry memory: one registered read, one write per cycle
    always_ff @(posedge i_clk) begin
        if (w_step && w_more) begin
            r_rd_data <= r_mem[r_rd_ptr[ADDR_W-1:0]];
        end
        if (i_cmd.append) begin
            r_mem[r_fill[ADDR_W-1:0]] <= r_value;
        end else if (i_cmd.shift_en && r_rd_vld) begin
            r_mem[r_wr_ptr] <= r_rd_data;
        end
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.append) begin
            r_fill <= r_fill + CNT_W'(1);
        end else if (i_cmd.dec_fill) begin
            r_fill <= r_fill - CNT_W'(1);
        end
    end

    // Status towards the controller
    always_comb begin
        o_sts.hit        = r_rd_vld && (r_rd_data == r_value);
        o_sts.scan_miss  = !r_rd_vld && !w_more;
        o_sts.shift_done = !r_rd_vld && !w_more;
        o_sts.full       = (r_fill >= CNT_W'(CAPACITY));
    end

    assign o_fill = r_fill;

endmodule

// ===== sv/ost_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the ordered set table: sequences search, append and
// compaction, and holds the result status. Depends on ost_pkg.
module ost_ctrl
    import ost_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    input  t_func   i_req_func,
    output logic    o_req_ready,
    output logic    o_rsp_valid,
    input  logic    i_rsp_ready,
    output t_status o_status,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } t_state;

    t_state  r_state, n_state;
    t_func   r_func;
    t_status r_status, n_status;

    // Next state, status and datapath commands
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.capture    = 1'b1;
                    o_cmd.start_scan = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_sts.hit) begin
                    n_state  = S_RESP;
                    n_status = ST_MISS;
                    case (r_func)
                        FN_MEMBER: n_status = ST_OK;
                        FN_REMOVE: begin
                            o_cmd.start_shift = 1'b1;
                            n_state           = S_SHIFT;
                        end
                        default:   n_status = ST_MISS;
                    endcase
                end else if (i_sts.scan_miss) begin
                    n_state  = S_RESP;
                    n_status = ST_MISS;
                    if (r_func == FN_INSERT) begin
                        if (i_sts.full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_cmd.append = 1'b1;
                            n_status     = ST_OK;
                        end
                    end
                end
            end
            S_SHIFT: begin
                o_cmd.shift_en = 1'b1;
                if (i_sts.shift_done) begin
                    o_cmd.dec_fill = 1'b1;
                    n_status       = ST_OK;
                    n_state        = S_RESP;
                end
            end
            S_RESP: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            if (r_state == S_IDLE && i_req_valid) begin
                r_func <= i_req_func;
            end
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_RESP);
    assign o_status    = r_status;

endmodule

// ===== sv/ordered_set_table_unit.sv =====
`timescale 1ns / 1ps
// Top level of the ordered set table: controller plus datapath.
// Depends on ost_pkg, ost_if, ost_ctrl and ost_dpath.
//
// Usage
//   i_req carries one item: func (member query, insert, remove) and value.
//   o_rsp returns one item per request: status and element_count.
//   Both are valid/ready channels; an item moves when valid and ready are high.
// Operation
//   The block handles one item at a time. After an item is taken the held
//   entries are searched one per cycle through the entry memory's single
//   read port, stopping at the first match. A remove then compacts the
//   entries after the hit, one per cycle.
//   i_req.ready is high again the cycle after the result is taken.
// Reset
//   Synchronous, active low; the table is left empty. No clearing pass.
// Stalls
//   The result is held on o_rsp until taken; no new item is accepted meanwhile.
module ordered_set_table_unit
    import ost_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    ost_req_if.sink   i_req,
    ost_rsp_if.source o_rsp
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    t_status w_status;
    logic [CNT_W-1:0]         w_fill;
    logic [CNT_W+COUNT_W-1:0] w_fill_ext;

    ost_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_func  (i_req.func),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_status    (w_status),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    ost_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_value (i_req.value),
        .o_sts   (w_sts),
        .o_fill  (w_fill)
    );

    // Count shown masked to the result field width
    assign w_fill_ext          = {{COUNT_W{1'b0}}, w_fill};
    assign o_rsp.status        = w_status;
    assign o_rsp.element_count = w_fill_ext[COUNT_W-1:0];

endmodule

// ===== sv/ost_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the ordered set table, bound to the top level.
// Depends on ost_pkg and ordered_set_table_unit.
module ost_checker
    import ost_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_valid,
    input logic                i_req_ready,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input logic [STATUS_W-1:0] i_status,
    input logic [COUNT_W-1:0]  i_count
);

    localparam logic [CNT_W+COUNT_W-1:0] CAP_EXT = (CNT_W+COUNT_W)'(CAPACITY);
    localparam logic [COUNT_W-1:0]       CAP_CNT = CAP_EXT[COUNT_W-1:0];

    // A pending result stays up until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result dropped before it was taken");

    // One item at a time: no request taken while a result is pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req_ready && i_rsp_valid))
        else $error("request accepted while a result is pending");

    // No result is shown the cycle after a request is taken
    a_no_instant_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_rsp_valid)
        else $error("result shown the cycle after accept");

    // Full status only with a full table
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status == ST_FULL) |-> (i_count == CAP_CNT))
        else $error("full status with a table that is not full");

endmodule

bind ordered_set_table_unit ost_checker u_ost_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_count     (o_rsp.element_count)
);

// ===== test/ordered_set_table_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ordered_set_table_unit: directed and random set operations
// checked against a queue-based shadow of the set. Depends on ost_pkg, ost_if and the RTL.
module ordered_set_table_unit_tb;
    import ost_pkg::*;

    // Unused operation code: changes nothing, reports a miss
    localparam t_func FN_UNUSED = 2'd3;
    localparam int POOL_N = 24;
    localparam int N_RANDOM = 850;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        t_func       func;
        logic [31:0] value;
    } t_set_req;

    typedef struct {
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_set_reply;

    logic i_clk;
    logic i_rst_n;

    ost_req_if req_ch ();
    ost_rsp_if rsp_ch ();

    ordered_set_table_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_set_req    pending_ops[$];
    t_set_reply  replies_due[$];
    logic [31:0] held_values[$];
    logic [31:0] value_pool[POOL_N];
    int          error_count;
    int          replies_seen;
    logic        hold_rsp;

    // Clock and the single reset at the start
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n       = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.func   = FN_MEMBER;
        req_ch.value  = '0;
        rsp_ch.ready  = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Shadow of the table: applies one operation, returns the reply it should give
    function automatic t_set_reply apply_set_op(input t_set_req op);
        t_set_reply r;
        int         slot;
        slot = -1;
        foreach (held_values[i]) begin
            if (slot < 0 && held_values[i] == op.value) slot = i;
        end
        r.status = ST_MISS;
        case (op.func)
            FN_MEMBER: begin
                if (slot >= 0) r.status = ST_OK;
            end
            FN_INSERT: begin
                // search comes first, so a duplicate on a full table is a miss
                if (slot >= 0) r.status = ST_MISS;
                else if (held_values.size() >= CAPACITY) r.status = ST_FULL;
                else begin
                    held_values.push_back(op.value);
                    r.status = ST_OK;
                end
            end
            FN_REMOVE: begin
                if (slot >= 0) begin
                    held_values.delete(slot);
                    r.status = ST_OK;
                end
            end
            default: ;
        endcase
        r.count = COUNT_W'(held_values.size());
        return r;
    endfunction

    task automatic queue_op(input t_func f, input logic [31:0] v);
        t_set_req op;
        op.func  = f;
        op.value = v;
        pending_ops.push_back(op);
    endtask

    // Stimulus: directed corner cases, then pool-based random traffic
    initial begin : stimulus
        int mix;
        int r;
        t_func f;
        logic [31:0] v;
        error_count  = 0;
        replies_seen = 0;

        // empty table
        queue_op(FN_MEMBER, 32'h0000_0000);
        queue_op(FN_REMOVE, 32'h0000_0005);
        // fill to capacity: most negative first, zero next, all ones and most positive last
        queue_op(FN_INSERT, 32'h8000_0000);
        queue_op(FN_INSERT, 32'h0000_0000);
        for (int k = 0; k < CAPACITY - 4; k++) queue_op(FN_INSERT, 32'h0000_0100 + k);
        queue_op(FN_INSERT, 32'hFFFF_FFFF);
        queue_op(FN_INSERT, 32'h7FFF_FFFF);
        // full table: new value, duplicate, queries, unused code
        queue_op(FN_INSERT, 32'h1234_5678);
        queue_op(FN_INSERT, 32'h8000_0000);
        queue_op(FN_MEMBER, 32'h7FFF_FFFF);
        queue_op(FN_MEMBER, 32'h5A5A_5A5A);
        queue_op(FN_UNUSED, 32'hA5A5_A5A5);
        // removes from middle, head, tail, then an absent one
        queue_op(FN_REMOVE, 32'h0000_0000);
        queue_op(FN_REMOVE, 32'h8000_0000);
        queue_op(FN_REMOVE, 32'h7FFF_FFFF);
        queue_op(FN_REMOVE, 32'h7FFF_FFFF);

        // value pool larger than the table so it fills and drains
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int k = 4; k < POOL_N; k++) value_pool[k] = $urandom;

        mix = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            // switch between insert-heavy, remove-heavy and balanced spells
            if (n % 40 == 0) mix = $urandom_range(0, 2);
            r = $urandom_range(0, 99);
            case (mix)
                0:       f = (r < 55) ? FN_INSERT : (r < 70) ? FN_REMOVE :
                             (r < 96) ? FN_MEMBER : FN_UNUSED;
                1:       f = (r < 15) ? FN_INSERT : (r < 70) ? FN_REMOVE :
                             (r < 96) ? FN_MEMBER : FN_UNUSED;
                default: f = (r < 35) ? FN_INSERT : (r < 65) ? FN_REMOVE :
                             (r < 96) ? FN_MEMBER : FN_UNUSED;
            endcase
            v = value_pool[$urandom_range(0, POOL_N - 1)];
            // fresh random values only where they cannot clog the table
            if (f != FN_INSERT && $urandom_range(0, 9) == 0) v = $urandom;
            queue_op(f, v);
        end
    end

    // Request driver: bursts of random length separated by random gaps
    always @(posedge i_clk) begin : req_driver
        int       burst_left;
        int       gap_left;
        logic     accepted;
        t_set_req op;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end else begin
            accepted = req_ch.valid && req_ch.ready;
            if (accepted) begin
                op = pending_ops.pop_front();
                replies_due.push_back(apply_set_op(op));
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 8);
                end
            end
            if (req_ch.valid && !accepted) begin
                // hold the offered item until taken
            end else if (gap_left > 0) begin
                gap_left--;
                req_ch.valid <= 1'b0;
            end else if (pending_ops.size() != 0) begin
                req_ch.valid <= 1'b1;
                req_ch.func  <= pending_ops[0].func;
                req_ch.value <= pending_ops[0].value;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Reply monitor and checker, with its own ready pattern
    always @(posedge i_clk) begin : rsp_monitor
        int         stall_left;
        int         stall_mode;
        int         stall_phase;
        logic       take;
        t_set_reply want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left  = 0;
            stall_mode  = 0;
            stall_phase = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                replies_seen++;
                if (replies_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected reply status %0d count %0d",
                                              rsp_ch.status, rsp_ch.element_count));
                end else begin
                    want = replies_due.pop_front();
                    if (rsp_ch.status !== want.status)
                        report_mismatch($sformatf("reply %0d: status %0d, want %0d",
                                                  replies_seen, rsp_ch.status, want.status));
                    if (rsp_ch.element_count !== want.count)
                        report_mismatch($sformatf("reply %0d: count %0d, want %0d",
                                                  replies_seen, rsp_ch.element_count,
                                                  want.count));
                end
            end
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(64, 200);
            end else begin
                stall_left--;
            end
            stall_phase++;
            case (stall_mode)
                0:       take = 1'b1;
                1:       take = 1'($urandom_range(0, 1));
                2:       take = ($urandom_range(0, 3) == 0);
                default: take = (stall_phase % 7) < 3;
            endcase
            rsp_ch.ready <= hold_rsp ? 1'b0 : take;
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input
    initial begin : rsp_hold_off
        hold_rsp = 1'b0;
        wait (replies_seen >= 60);
        @(posedge i_clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rsp <= 1'b0;
    end

    // End of run: everything sent and answered, then a short drain
    initial begin : run_end
        wait (i_rst_n === 1'b1);
        while (pending_ops.size() != 0 || req_ch.valid || replies_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (replies_due.size() != 0)
            report_mismatch($sformatf("%0d replies never arrived", replies_due.size()));
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
